>>> src/poly_voice_allocator_macros.svh
// ----------------------------------------------------------------------------
// poly_voice_allocator_macros: assertion macros
// Shared property forms used by the voice allocator checks.
// ----------------------------------------------------------------------------
`ifndef POLY_VOICE_ALLOCATOR_MACROS_SVH
`define POLY_VOICE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PVA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PVA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg: voice allocator package
// Table size, MIDI constants, action codes and sequencer types.
// ----------------------------------------------------------------------------
package pva_pkg;

    localparam int VOICES = 8;
    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int MASK_W = (VOICES > 8) ? VOICES : 8;

    localparam logic [31:0] SEED_BASE   = 32'ha511e9b3;
    localparam logic [31:0] SEED_MUL    = 32'h9e3779b9;
    localparam logic [13:0] BEND_CENTER = 14'd8192;

    localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
    localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
    localparam logic [3:0] TYPE_BEND     = 4'he;
    localparam logic [3:0] TYPE_CTRL     = 4'hb;

    localparam logic [6:0] CTRL_SOUND_OFF = 7'd120;
    localparam logic [6:0] CTRL_NOTES_OFF = 7'd123;

    localparam logic [2:0] ACT_IGNORED  = 3'd0;
    localparam logic [2:0] ACT_STARTED  = 3'd1;
    localparam logic [2:0] ACT_RELEASED = 3'd2;
    localparam logic [2:0] ACT_BEND     = 3'd3;
    localparam logic [2:0] ACT_FREED    = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEED,
        ST_DONE
    } pva_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_START,
        OP_RELEASE,
        OP_RELEASE_ALL,
        OP_BEND,
        OP_FREE
    } pva_op_t;

endpackage

>>> src/poly_voice_allocator.sv
// ----------------------------------------------------------------------------
// poly_voice_allocator: polyphonic voice table
// Classes MIDI messages and voice-finished events, allocates voices with
// oldest-stamp stealing, releases matching voices and tracks pitch bend.
// ----------------------------------------------------------------------------
//  channel | signals                                | direction
//  --------+----------------------------------------+----------
//  in      | in_valid/in_ready, cmd..done_voice     | sink
//  out     | out_valid/out_ready, action..bend_now  | source
//
//  Note on, note off and the all-notes-off/all-sound-off controllers walk the
//  voice table one entry a cycle; a start also tracks the oldest stamp through
//  one stamp comparator. Reset clears the whole table at once.
//  A new item transfers while the previous result waits on out_ready; the
//  sequencer holds its result until the output register frees.
// ----------------------------------------------------------------------------
`include "poly_voice_allocator_macros.svh"

module poly_voice_allocator
    import pva_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [1:0]         msg_len,
    input  logic [7:0]         status,
    input  logic [6:0]         data1,
    input  logic [6:0]         data2,
    input  logic [2:0]         done_voice,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         action,
    output logic [2:0]         voice_index,
    output logic               stolen,
    output logic [7:0]         release_mask,
    output logic [6:0]         note_out,
    output logic [6:0]         velocity_out,
    output logic [31:0]        age_out,
    output logic [31:0]        noise_seed,
    output logic signed [13:0] bend_now
);

    pva_state_t state_reg, state_next;

    logic              voice_active_reg [VOICES];
    logic              voice_gate_reg   [VOICES];
    logic [6:0]        voice_note_reg   [VOICES];
    logic [31:0]       voice_stamp_reg  [VOICES];
    logic [31:0]       age_counter_reg;
    logic [13:0]       bend_offset_reg;

    pva_op_t           op_reg, op_dec;
    logic [6:0]        d1_reg, d2_reg;
    logic [2:0]        done_reg;
    logic [VIDX_W-1:0] idx_reg;
    logic              free_found_reg;
    logic [VIDX_W-1:0] free_idx_reg;
    logic [VIDX_W-1:0] min_idx_reg;
    logic [31:0]       min_stamp_reg;
    logic [VOICES-1:0] mask_reg;
    logic [VIDX_W-1:0] sel_reg;
    logic              stole_reg;
    logic [31:0]       prod_reg;

    logic              out_valid_reg;
    logic [2:0]        action_reg;
    logic [2:0]        voice_index_reg;
    logic              stolen_reg;
    logic [7:0]        release_mask_reg;
    logic [6:0]        note_out_reg;
    logic [6:0]        velocity_out_reg;
    logic [31:0]       age_out_reg;
    logic [31:0]       noise_seed_reg;
    logic [13:0]       bend_now_reg;

    logic              in_xfer;
    logic              slot_free;
    logic              scan_last;
    logic              stamp_less;
    logic [VIDX_W-1:0] sel_pick;
    logic [VIDX_W-1:0] done_idx;
    logic [7:0]        sel_wide;
    logic [MASK_W-1:0] mask_wide;
    logic [13:0]       bend_raw;

    always_comb
    begin
        op_dec = OP_NONE;
        if (cmd) begin
            if (32'(done_voice) < VOICES) begin
                op_dec = OP_FREE;
            end
        end else if (msg_len == 2'd3) begin
            if (status[7:4] == TYPE_NOTE_ON && data2 != 7'd0) begin
                op_dec = OP_START;
            end else if (status[7:4] == TYPE_NOTE_OFF || status[7:4] == TYPE_NOTE_ON) begin
                op_dec = OP_RELEASE;
            end else if (status[7:4] == TYPE_BEND) begin
                op_dec = OP_BEND;
            end else if (status[7:4] == TYPE_CTRL &&
                         (data1 == CTRL_SOUND_OFF || data1 == CTRL_NOTES_OFF)) begin
                op_dec = OP_RELEASE_ALL;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    if (op_dec == OP_START || op_dec == OP_RELEASE ||
                        op_dec == OP_RELEASE_ALL) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_last) begin
                    state_next = (op_reg == OP_START) ? ST_SEED : ST_DONE;
                end
            end
            ST_SEED:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE);
        in_xfer    = in_valid && in_ready;
        slot_free  = !out_valid_reg || out_ready;
        scan_last  = (32'(idx_reg) == VOICES - 1);
        stamp_less = (voice_stamp_reg[idx_reg] < min_stamp_reg);
        sel_pick   = free_found_reg ? free_idx_reg : min_idx_reg;
        done_idx   = VIDX_W'(done_reg);
        sel_wide   = 8'(sel_reg);
        mask_wide  = MASK_W'(mask_reg);
        bend_raw   = {d2_reg, d1_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int v = 0; v < VOICES; v++) begin
                voice_active_reg[v] <= 1'b0;
                voice_gate_reg[v]   <= 1'b0;
                voice_note_reg[v]   <= 7'd0;
                voice_stamp_reg[v]  <= 32'd0;
            end
            age_counter_reg <= 32'd0;
            bend_offset_reg <= 14'd0;
            out_valid_reg   <= 1'b0;
            op_reg          <= OP_NONE;
            idx_reg         <= '0;
            free_found_reg  <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer) begin
                        op_reg         <= op_dec;
                        idx_reg        <= '0;
                        free_found_reg <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    if (op_reg == OP_START) begin
                        if (!voice_active_reg[idx_reg] && !free_found_reg) begin
                            free_found_reg <= 1'b1;
                        end
                    end else if (voice_active_reg[idx_reg] &&
                                 (op_reg == OP_RELEASE_ALL ||
                                  voice_note_reg[idx_reg] == d1_reg)) begin
                        voice_gate_reg[idx_reg] <= 1'b0;
                    end
                    if (!scan_last) begin
                        idx_reg <= idx_reg + VIDX_W'(1);
                    end
                end
                ST_SEED:
                begin
                    voice_active_reg[sel_pick] <= 1'b1;
                    voice_gate_reg[sel_pick]   <= 1'b1;
                    voice_note_reg[sel_pick]   <= d1_reg;
                    voice_stamp_reg[sel_pick]  <= age_counter_reg + 32'd1;
                    age_counter_reg            <= age_counter_reg + 32'd1;
                end
                ST_DONE:
                begin
                    if (slot_free) begin
                        out_valid_reg <= 1'b1;
                        if (op_reg == OP_FREE) begin
                            voice_active_reg[done_idx] <= 1'b0;
                            voice_gate_reg[done_idx]   <= 1'b0;
                            voice_note_reg[done_idx]   <= 7'd0;
                            voice_stamp_reg[done_idx]  <= 32'd0;
                        end
                        if (op_reg == OP_BEND) begin
                            bend_offset_reg <= bend_raw - BEND_CENTER;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer) begin
                    d1_reg        <= data1;
                    d2_reg        <= data2;
                    done_reg      <= done_voice;
                    mask_reg      <= '0;
                    min_idx_reg   <= '0;
                    min_stamp_reg <= 32'd0;
                end
            end
            ST_SCAN:
            begin
                if (op_reg == OP_START) begin
                    if (!voice_active_reg[idx_reg] && !free_found_reg) begin
                        free_idx_reg <= idx_reg;
                    end
                    if (idx_reg == '0 || stamp_less) begin
                        min_idx_reg   <= idx_reg;
                        min_stamp_reg <= voice_stamp_reg[idx_reg];
                    end
                end else if (voice_active_reg[idx_reg] &&
                             (op_reg == OP_RELEASE_ALL ||
                              voice_note_reg[idx_reg] == d1_reg)) begin
                    mask_reg[idx_reg] <= 1'b1;
                end
            end
            ST_SEED:
            begin
                sel_reg   <= sel_pick;
                stole_reg <= !free_found_reg;
                prod_reg  <= 32'(d1_reg * SEED_MUL);
            end
            ST_DONE:
            begin
                if (slot_free) begin
                    action_reg       <= ACT_IGNORED;
                    voice_index_reg  <= 3'd0;
                    stolen_reg       <= 1'b0;
                    release_mask_reg <= 8'd0;
                    note_out_reg     <= 7'd0;
                    velocity_out_reg <= 7'd0;
                    age_out_reg      <= 32'd0;
                    noise_seed_reg   <= 32'd0;
                    bend_now_reg     <= bend_offset_reg;
                    case (op_reg)
                        OP_START:
                        begin
                            action_reg       <= ACT_STARTED;
                            voice_index_reg  <= sel_wide[2:0];
                            stolen_reg       <= stole_reg;
                            note_out_reg     <= d1_reg;
                            velocity_out_reg <= d2_reg;
                            age_out_reg      <= age_counter_reg;
                            noise_seed_reg   <= SEED_BASE ^ prod_reg ^ age_counter_reg;
                        end
                        OP_RELEASE, OP_RELEASE_ALL:
                        begin
                            action_reg       <= ACT_RELEASED;
                            release_mask_reg <= mask_wide[7:0];
                        end
                        OP_BEND:
                        begin
                            action_reg   <= ACT_BEND;
                            bend_now_reg <= bend_raw - BEND_CENTER;
                        end
                        OP_FREE:
                        begin
                            action_reg      <= ACT_FREED;
                            voice_index_reg <= done_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign action       = action_reg;
    assign voice_index  = voice_index_reg;
    assign stolen       = stolen_reg;
    assign release_mask = release_mask_reg;
    assign note_out     = note_out_reg;
    assign velocity_out = velocity_out_reg;
    assign age_out      = age_out_reg;
    assign noise_seed   = noise_seed_reg;
    assign bend_now     = bend_now_reg;

    `PVA_ASSERT_NEXT(a_scan_exit, state_reg == ST_SCAN && scan_last,
        state_reg == ST_SEED || state_reg == ST_DONE, "scan did not end after last voice")
    `PVA_ASSERT_NEXT(a_seed_commit, state_reg == ST_SEED,
        voice_active_reg[sel_reg] && voice_gate_reg[sel_reg], "started voice not gated on")
    `PVA_ASSERT_NEXT(a_age_step, state_reg == ST_SEED,
        age_counter_reg == $past(age_counter_reg) + 32'd1, "age counter did not advance")
    `PVA_ASSERT_SAME(a_idle_fields, out_valid_reg && action_reg != ACT_STARTED,
        age_out_reg == 32'd0 && noise_seed_reg == 32'd0 && !stolen_reg, "start fields leak")

endmodule
